FILE: src/wsfd_pkg.sv
// wsfd_pkg: shared types and codes for the websocket frame deframer
// no dependencies; imported by websocket_frame_deframer and tb_websocket_frame_deframer

package wsfd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_LENHI = 3'd2,
		PH_LENLO = 3'd3,
		PH_MASK  = 3'd4,
		PH_DATA  = 3'd5,
		PH_HALT  = 3'd6
	} phase_t;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] err_t;

	localparam kind_t KIND_BYTE  = 2'd0;
	localparam kind_t KIND_EMPTY = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	localparam err_t ERR_MASK      = 2'd0;
	localparam err_t ERR_TOO_BIG   = 2'd1;
	localparam err_t ERR_PAY_SHORT = 2'd2;
	localparam err_t ERR_HDR_SHORT = 2'd3;

	localparam logic [6:0]  LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0]  LEN_CODE_EXT64 = 7'd127;
	localparam logic [15:0] MAX_EXT_LEN_RST = 16'd131;
	localparam logic [15:0] MASK_BYTES = 16'd4;

endpackage

FILE: src/websocket_frame_deframer.sv
// websocket_frame_deframer: client-to-server websocket header parser and unmasker
// depends on wsfd_pkg
//
// usage:
// - s_* takes the received stream one byte a request; s_tuser set marks stream end
// - m_* gives one result per payload byte, one per empty frame, or one error
// - m_tlast marks the last payload byte of a frame and the empty-frame result
// - cfg_we/cfg_wdata write the largest length allowed in the 16-bit length form
// - a result is registered and appears on m_* in the cycle after its byte is taken
// - throughput: one byte per cycle unless the receiver stalls a held result; all parsing
//   is one pass of logic ahead of the output register
// - reset clears the parser to the first header byte and the limit to 131
// - after an error no more results appear until reset
// - while the receiver stalls with a result held, s_tready drops; it stays high
//   when the output register is empty or being drained in the same cycle

module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // stream_ended
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // payload_byte[7:0], frame_opcode[11:8],
	                               // final_fragment[12], error_code[14:13], zero[15]
	output logic [1:0]  m_tuser,   // result_kind
	output logic        m_tlast,   // last_of_frame
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata  // max_extended_length
);
	import wsfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic [15:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] max_len_q;

	logic        res_valid;
	kind_t       res_kind;
	logic [7:0]  res_pay;
	logic        res_last;
	err_t        res_err;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	logic        accept;
	logic [16:0] cnt_inc;
	logic [15:0] len_full;
	logic [7:0]  key_byte;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cnt_inc  = {1'b0, cnt_q} + 17'd1;
	assign len_full = {len_q[15:8], s_tdata};

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		fin_d     = fin_q;
		len_d     = len_q;
		key_d     = key_q;
		cnt_d     = cnt_q;
		res_valid = 1'b0;
		res_kind  = KIND_BYTE;
		res_pay   = 8'd0;
		res_last  = 1'b0;
		res_err   = ERR_MASK;
		if (phase_q != PH_HALT && s_tuser) begin
			if (phase_q != PH_HDR0) begin
				phase_d   = PH_HALT;
				res_valid = 1'b1;
				res_kind  = KIND_ERROR;
				res_err   = (phase_q == PH_DATA) ? ERR_PAY_SHORT : ERR_HDR_SHORT;
			end
		end else begin
			unique case (phase_q)
				PH_HDR0: begin
					opcode_d = s_tdata[3:0];
					fin_d    = s_tdata[7];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					if (!s_tdata[7]) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_err   = ERR_MASK;
					end else if (s_tdata[6:0] == LEN_CODE_EXT64) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_err   = ERR_TOO_BIG;
					end else begin
						len_d   = {9'd0, s_tdata[6:0]};
						cnt_d   = 16'd0;
						phase_d = (s_tdata[6:0] == LEN_CODE_EXT16) ? PH_LENHI : PH_MASK;
					end
				end
				PH_LENHI: begin
					len_d   = {s_tdata, 8'd0};
					phase_d = PH_LENLO;
				end
				PH_LENLO: begin
					len_d = len_full;
					if (len_full > max_len_q) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_err   = ERR_TOO_BIG;
					end else begin
						cnt_d   = 16'd0;
						phase_d = PH_MASK;
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], s_tdata};
					if (cnt_inc[15:0] < MASK_BYTES) begin
						cnt_d = cnt_inc[15:0];
					end else begin
						cnt_d = 16'd0;
						if (len_q == 16'd0) begin
							phase_d   = PH_HDR0;
							res_valid = 1'b1;
							res_kind  = KIND_EMPTY;
							res_last  = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					res_valid = 1'b1;
					res_kind  = KIND_BYTE;
					res_pay   = s_tdata ^ key_byte;
					res_last  = (cnt_inc >= {1'b0, len_q});
					if (res_last) begin
						cnt_d   = 16'd0;
						phase_d = PH_HDR0;
					end else begin
						cnt_d = cnt_inc[15:0];
					end
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= 4'd0;
			fin_q     <= 1'b0;
			len_q     <= 16'd0;
			key_q     <= 32'd0;
			cnt_q     <= 16'd0;
			max_len_q <= MAX_EXT_LEN_RST;
		end else begin
			if (accept) begin
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				fin_q    <= fin_d;
				len_q    <= len_d;
				key_q    <= key_d;
				cnt_q    <= cnt_d;
			end
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= accept && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			m_tdata_q <= {1'b0, res_err, fin_d, opcode_d, res_pay};
			m_tuser_q <= res_kind;
			m_tlast_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: bench/tb_websocket_frame_deframer.sv
// tb_websocket_frame_deframer: self-checking bench for the websocket frame deframer
// drives framed byte streams with random gaps and stalls, predicts each result in-bench
// depends on wsfd_pkg and websocket_frame_deframer

module tb_websocket_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import wsfd_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       ended;
	} ws_req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
		err_t       err;
	} ws_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	ws_req_t    byte_q[$];
	ws_req_t    cur_req;
	ws_result_t unmasked_q[$];
	ws_result_t want, got;

	phase_t      ps_phase;
	logic [3:0]  ps_opcode;
	logic        ps_fin;
	logic [15:0] ps_length;
	logic [31:0] ps_key;
	logic [15:0] ps_count;
	logic [15:0] len_limit;

	logic calm = 1'b0;
	int   n_sent = 0;
	int   n_taken = 0;
	int   n_results = 0;
	int   n_bad = 0;
	int   quiet_cycles = 0;

	websocket_frame_deframer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function void flag_error(input err_t code);
		ps_phase = PH_HALT;
		unmasked_q.push_back('{KIND_ERROR, 8'h00, ps_opcode, ps_fin, 1'b0, code});
	endfunction

	function void unmask_step(input logic [7:0] b, input logic ended);
		logic [7:0] key_byte;
		logic       last;
		if (ps_phase == PH_HALT)
			return;
		if (ended) begin
			if (ps_phase != PH_HDR0)
				flag_error(ps_phase == PH_DATA ? ERR_PAY_SHORT : ERR_HDR_SHORT);
			return;
		end
		case (ps_phase)
			PH_HDR0: begin
				ps_opcode = b[3:0];
				ps_fin = b[7];
				ps_phase = PH_HDR1;
			end
			PH_HDR1: begin
				if (!b[7])
					flag_error(ERR_MASK);
				else if (b[6:0] == LEN_CODE_EXT64)
					flag_error(ERR_TOO_BIG);
				else begin
					ps_length = {9'd0, b[6:0]};
					ps_count = '0;
					ps_phase = (b[6:0] == LEN_CODE_EXT16) ? PH_LENHI : PH_MASK;
				end
			end
			PH_LENHI: begin
				ps_length = {b, 8'h00};
				ps_phase = PH_LENLO;
			end
			PH_LENLO: begin
				ps_length[7:0] = b;
				if (ps_length > len_limit)
					flag_error(ERR_TOO_BIG);
				else begin
					ps_count = '0;
					ps_phase = PH_MASK;
				end
			end
			PH_MASK: begin
				ps_key = {ps_key[23:0], b};
				ps_count = ps_count + 16'd1;
				if (ps_count == MASK_BYTES) begin
					ps_count = '0;
					if (ps_length == 16'd0) begin
						ps_phase = PH_HDR0;
						unmasked_q.push_back('{KIND_EMPTY, 8'h00, ps_opcode, ps_fin, 1'b1,
							ERR_MASK});
					end else
						ps_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				key_byte = ps_key[8 * (3 - ps_count[1:0]) +: 8];
				last = (int'(ps_count) + 1 >= int'(ps_length));
				unmasked_q.push_back('{KIND_BYTE, b ^ key_byte, ps_opcode, ps_fin, last,
					ERR_MASK});
				ps_count = ps_count + 16'd1;
				if (last) begin
					ps_count = '0;
					ps_phase = PH_HDR0;
				end
			end
			default: ;
		endcase
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				unmask_step(s_tdata, s_tuser);
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
					cur_req = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_req.data;
					s_tuser <= cur_req.ended;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[12], m_tlast,
					m_tdata[14:13]};
				if (unmasked_q.size() == 0) begin
					if (n_bad < 10)
						$display("result %0d: none expected, got kind %0d byte %02h",
							n_results, got.kind, got.payload);
					n_bad++;
				end else begin
					want = unmasked_q.pop_front();
					if (got.kind !== want.kind || got.payload !== want.payload
							|| got.opcode !== want.opcode || got.fin !== want.fin
							|| got.last !== want.last || got.err !== want.err
							|| m_tdata[15] !== 1'b0) begin
						if (n_bad < 10) begin
							$display("result %0d: expected kind %0d byte %02h op %h fin %b last %b err %0d",
								n_results, want.kind, want.payload, want.opcode, want.fin,
								want.last, want.err);
							$display("result %0d: got kind %0d byte %02h op %h fin %b last %b err %0d pad %b",
								n_results, got.kind, got.payload, got.opcode, got.fin,
								got.last, got.err, m_tdata[15]);
						end
						n_bad++;
					end
				end
				n_results++;
			end
			m_tready <= calm || $urandom_range(99) >= 7;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("websocket_frame_deframer: mismatch");
				$finish;
			end
		end
	end

	task automatic push_req(input logic [7:0] data, input logic ended);
		byte_q.push_back('{data, ended});
		n_sent++;
	endtask

	task automatic add_frame(input logic fin, input logic [3:0] opcode, input int len,
			input logic ext, input logic [31:0] key);
		push_req({fin, 3'($urandom), opcode}, 1'b0);
		if (ext) begin
			push_req({1'b1, LEN_CODE_EXT16}, 1'b0);
			push_req(len[15:8], 1'b0);
			push_req(len[7:0], 1'b0);
		end else
			push_req({1'b1, 7'(len)}, 1'b0);
		for (int i = 0; i < 4; i++)
			push_req(key[31 - 8 * i -: 8], 1'b0);
		for (int i = 0; i < len; i++)
			push_req(8'($urandom), 1'b0);
	endtask

	task automatic rand_frame();
		int   pick;
		int   len;
		int   cap;
		logic ext;
		pick = $urandom_range(99);
		ext = 1'b0;
		cap = (len_limit < 300) ? int'(len_limit) : 300;
		if (pick < 10)
			len = 0;
		else if (pick < 60)
			len = $urandom_range(8, 1);
		else if (pick < 85)
			len = $urandom_range(40, 9);
		else if (pick < 94)
			len = $urandom_range(125, 41);
		else begin
			ext = 1'b1;
			len = (pick >= 98 && len_limit <= 300) ? int'(len_limit) : $urandom_range(cap, 0);
		end
		if (!ext && len <= len_limit && $urandom_range(4) == 0)
			ext = 1'b1;
		// stream end between frames is ignored
		if ($urandom_range(19) == 0)
			push_req(8'($urandom), 1'b1);
		add_frame(1'($urandom_range(1)), 4'($urandom_range(15)), len, ext, $urandom);
	endtask

	task automatic rand_frames(input int n);
		int start;
		start = n_sent;
		while (n_sent - start < n)
			rand_frame();
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (n_taken != n_sent);
		while (unmasked_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_limit = value;
	endtask

	task automatic broken_tail();
		int         pick;
		int         len;
		logic [7:0] hdr0;
		pick = $urandom_range(6);
		hdr0 = 8'($urandom);
		push_req(hdr0, 1'b0);
		case (pick)
			0: push_req({1'b0, 7'($urandom)}, 1'b0);
			1: push_req({1'b1, LEN_CODE_EXT64}, 1'b0);
			2: begin
				len = $urandom_range(65535, int'(len_limit) + 1);
				push_req({1'b1, LEN_CODE_EXT16}, 1'b0);
				push_req(len[15:8], 1'b0);
				push_req(len[7:0], 1'b0);
			end
			3: push_req(8'($urandom), 1'b1);
			4: begin
				push_req({1'b1, LEN_CODE_EXT16}, 1'b0);
				if ($urandom_range(1))
					push_req(8'($urandom), 1'b0);
				push_req(8'($urandom), 1'b1);
			end
			5: begin
				push_req({1'b1, 7'($urandom_range(125))}, 1'b0);
				repeat ($urandom_range(3))
					push_req(8'($urandom), 1'b0);
				push_req(8'($urandom), 1'b1);
			end
			default: begin
				len = $urandom_range(20, 1);
				push_req({1'b1, 7'(len)}, 1'b0);
				repeat (4 + $urandom_range(len - 1))
					push_req(8'($urandom), 1'b0);
				push_req(8'($urandom), 1'b1);
			end
		endcase
		// halted: everything after is swallowed
		repeat (12)
			push_req(8'($urandom), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		ps_phase = PH_HDR0;
		ps_opcode = '0;
		ps_fin = 1'b0;
		ps_length = '0;
		ps_key = '0;
		ps_count = '0;
		len_limit = MAX_EXT_LEN_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		add_frame(1'b1, 4'h0, 0, 1'b0, 32'h0000_0000);
		add_frame(1'b0, 4'hF, 1, 1'b0, 32'hFFFF_FFFF);
		push_req(8'hFF, 1'b1);
		add_frame(1'b1, 4'h8, 5, 1'b1, 32'h0123_4567);
		settle();

		rand_frames(120);
		settle();

		write_limit(16'd0);
		rand_frames(100);
		settle();

		write_limit(16'hFFFF);
		calm = 1'b1;
		rand_frames(30);
		add_frame(1'b1, 4'h2, 257, 1'b1, $urandom);
		rand_frames(20);
		settle();
		calm = 1'b0;

		write_limit(16'($urandom_range(400, 126)));
		rand_frames(120);
		settle();

		rand_frames(30);
		broken_tail();
		settle();
		repeat (8) @(posedge clk);

		if (n_bad == 0)
			$display("websocket_frame_deframer: match");
		else
			$display("websocket_frame_deframer: mismatch");
		$finish;
	end

endmodule
